>>> design/ftsc_pkg.sv
// Shared widths and constants for the frame time spike clamp.
package ftsc_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int SCALE_W    = 16;
	localparam int SCALE_FRAC = 8;
	localparam int MUL_W      = SAMPLE_W + SCALE_W;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [SCALE_W-1:0]  scale_t;
	typedef logic [MUL_W-1:0]    product_t;

	localparam scale_t SCALE_ONE = scale_t'(1 << SCALE_FRAC);

endpackage

>>> design/ftsc_ring.sv
// Sample ring memory: one write port and one registered read port.
module ftsc_ring #(
	parameter int DEPTH = 30,
	parameter int AW    = 5
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  ftsc_pkg::sample_t   wr_data,
	input  logic [AW-1:0]       rd_addr,
	output ftsc_pkg::sample_t   rd_data
);
	import ftsc_pkg::*;

	sample_t mem_q [DEPTH];
	sample_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

>>> design/ftsc_div.sv
// Restoring divider, one quotient bit per cycle.
module ftsc_div #(
	parameter int NW = 38,
	parameter int DW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [NW-1:0] quotient
);
	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

endmodule

>>> design/frame_time_spike_clamp_top.sv
// Frame time spike clamp: sequencer, shared adder and multiplier, ring and divider.
//
//   channel   signals                                        direction
//   in        in_valid, in_stall, elapsed_ticks              sample into block
//   out       out_valid, out_stall, clamped_ticks,
//             scaled_ticks, was_clamped                      result out of block
//   cfg       cfg_we, cfg_wdata                              time_scale write
//
// An item that is not clamped passes through the add, subtract, multiply, compare,
// scale and done steps before the next accept; a clamped item also waits in a divide
// step while the bit-serial divider computes twice the sum over the count.
// The result waits in an output register, so the next item is taken while it is stalled.
// Reset clears the window sum, count and ring pointers and sets time_scale to 1.0.
module frame_time_spike_clamp_top #(
	parameter int WINDOW = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ftsc_pkg::sample_t   elapsed_ticks,
	output logic                out_valid,
	input  logic                out_stall,
	output ftsc_pkg::sample_t   clamped_ticks,
	output ftsc_pkg::sample_t   scaled_ticks,
	output logic                was_clamped,
	input  logic                cfg_we,
	input  ftsc_pkg::scale_t    cfg_wdata
);
	import ftsc_pkg::*;

	localparam int IDX_W = $clog2(WINDOW);
	localparam int CNT_W = $clog2(WINDOW);
	localparam int SUM_W = SAMPLE_W + CNT_W;
	localparam int AL_W  = SUM_W + 1;
	localparam int HALF  = WINDOW / 2;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ADD   = 3'd1;
	localparam logic [2:0] ST_SUB   = 3'd2;
	localparam logic [2:0] ST_MULT  = 3'd3;
	localparam logic [2:0] ST_CMP   = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_SCALE = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [IDX_W-1:0] head_nx;
	logic [IDX_W-1:0] tail_nx;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic             full_q;
	scale_t           scale_q;
	sample_t          sample_q;
	sample_t          clamped_q;
	logic             flag_q;
	product_t         mul_q;
	logic             out_valid_q;
	sample_t          out_clamped_q;
	sample_t          out_scaled_q;
	logic             out_flag_q;

	sample_t          ring_rd;
	logic [AL_W-1:0]  twice;
	logic [AL_W-1:0]  alu_a;
	logic [AL_W-1:0]  alu_b;
	logic             alu_sub;
	logic [AL_W:0]    alu_res;
	sample_t          mul_a;
	scale_t           mul_b;
	logic             clamp_hit;
	logic             div_start;
	logic             div_busy;
	logic [AL_W-1:0]  div_quo;
	sample_t          div_sat;
	sample_t          scaled_sat;
	logic             in_take;
	logic             out_load;

	assign in_stall  = state_q != ST_IDLE;
	assign in_take   = in_valid && !in_stall;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign head_nx = (head_q == IDX_W'(WINDOW - 1)) ? '0 : head_q + 1'b1;
	assign tail_nx = (tail_q == IDX_W'(WINDOW - 1)) ? '0 : tail_q + 1'b1;
	assign twice   = {sum_q, 1'b0};

	ftsc_ring #(
		.DEPTH (WINDOW),
		.AW    (IDX_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (state_q == ST_ADD),
		.wr_addr (head_q),
		.wr_data (sample_q),
		.rd_addr (tail_q),
		.rd_data (ring_rd)
	);

	// Shared add/subtract unit: sum update, oldest-sample drop, clamp test.
	always_comb begin
		alu_a   = AL_W'(sum_q);
		alu_b   = AL_W'(sample_q);
		alu_sub = 1'b0;
		case (state_q)
			ST_SUB: begin
				alu_b   = AL_W'(ring_rd);
				alu_sub = 1'b1;
			end
			ST_CMP: begin
				alu_a   = AL_W'(mul_q[SUM_W-1:0]);
				alu_b   = twice;
				alu_sub = 1'b1;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
	                         : ({1'b0, alu_a} + {1'b0, alu_b});

	// A clear borrow means sample * count >= 2 * sum.
	assign clamp_hit = (count_q > CNT_W'(HALF)) && !alu_res[AL_W];
	assign div_start = (state_q == ST_CMP) && clamp_hit;

	// Shared multiplier: sample * count for the test, clamped * scale for the output.
	assign mul_a = (state_q == ST_MULT) ? sample_q : clamped_q;
	assign mul_b = (state_q == ST_MULT) ? SCALE_W'(count_q) : scale_q;

	ftsc_div #(
		.NW (AL_W),
		.DW (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (twice),
		.divisor  (count_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign div_sat    = (div_quo[AL_W-1:SAMPLE_W] != '0) ? '1 : div_quo[SAMPLE_W-1:0];
	assign scaled_sat = (mul_q[MUL_W-1:SAMPLE_W+SCALE_FRAC] != '0) ? '1
	                    : mul_q[SAMPLE_W+SCALE_FRAC-1:SCALE_FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			full_q      <= 1'b0;
			scale_q     <= SCALE_ONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				scale_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					sum_q   <= alu_res[SUM_W-1:0];
					head_q  <= head_nx;
					full_q  <= head_nx == tail_q;
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					if (full_q) begin
						sum_q  <= alu_res[SUM_W-1:0];
						tail_q <= tail_nx;
					end else begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_MULT;
				end
				ST_MULT: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= clamp_hit ? ST_DIV : ST_SCALE;
				end
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= elapsed_ticks;
		end
		if (state_q == ST_MULT || state_q == ST_SCALE) begin
			mul_q <= MUL_W'(mul_a) * MUL_W'(mul_b);
		end
		if (state_q == ST_CMP) begin
			clamped_q <= sample_q;
			flag_q    <= clamp_hit;
		end else if (state_q == ST_DIV && !div_busy) begin
			clamped_q <= div_sat;
		end
		if (out_load) begin
			out_clamped_q <= clamped_q;
			out_scaled_q  <= scaled_sat;
			out_flag_q    <= flag_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign clamped_ticks = out_clamped_q;
	assign scaled_ticks  = out_scaled_q;
	assign was_clamped   = out_flag_q;

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW - 1))
		else $error("window count beyond ring capacity");

	a_ptr_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |->
			(((int'(tail_q) + int'(count_q)) >= WINDOW)
				? (int'(tail_q) + int'(count_q) - WINDOW)
				: (int'(tail_q) + int'(count_q))) == int'(head_q))
		else $error("ring pointers disagree with window count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUB && full_q) |-> count_q == CNT_W'(WINDOW - 1))
		else $error("ring reported full with a short window");

	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == ST_DIV)
		else $error("divider running outside the divide step");
`endif

endmodule
